// ===== sv/ecc_pkg.sv =====
// Package for the elevator car controller.
// Holds the mode and sequencer encodings, table entry types and saturating helpers.
// No dependencies.
package ecc_pkg;

  localparam int FLOORS     = 32;
  localparam int RIDE_CAP   = 16;
  localparam int WAIT_CAP   = 32;
  localparam int MOVE_COST  = 1;
  localparam int CLOSE_COST = 10;

  typedef enum logic [2:0] {
    M_HOLD  = 3'd0,
    M_UP    = 3'd1,
    M_DOWN  = 3'd2,
    M_OPEN  = 3'd3,
    M_CLOSE = 3'd4,
    M_STOP  = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_MOVE,
    S_SCAN_R,
    S_SCAN_W,
    S_DECIDE,
    S_ALIGHT,
    S_BOARD,
    S_BOARD_DUP,
    S_AGE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [5:0]  dest;
  } rider_t;

  typedef struct packed {
    logic [15:0] id;
    logic [5:0]  start;
    logic [5:0]  dest;
    logic [15:0] wait_cnt;
  } waiter_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] a);
    return (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction

endpackage

// ===== sv/elevator_car_controller_unit.sv =====
// Top level of the elevator car controller: request handshake, sequencer and tables.
// Depends on ecc_pkg.
//
// One request is worked on at a time and in_ready is low until its result is registered.
// An add scans the waiting table for a duplicate id.
// A tick does the move, target scan and decision,
// plus one more pass over the riding table when riders alight, or over the waiting table
// for aging, or for boarding, where each boarding candidate also scans the riding table.
// One table entry is read per cycle.
module elevator_car_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [15:0] passenger_id,
  input  logic [5:0]  start_floor,
  input  logic [5:0]  dest_floor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [5:0]  car_floor,
  output logic [2:0]  car_mode,
  output logic [4:0]  riders,
  output logic [5:0]  waiters,
  output logic [31:0] elapsed_steps,
  output logic [31:0] energy_cost,
  output logic [15:0] boarded_total,
  output logic [31:0] wait_total
);
  import ecc_pkg::*;

  state_t state, state_next;

  rider_t  rider_tab [RIDE_CAP];
  waiter_t waiter_tab [WAIT_CAP];

  logic [5:0]  floor_now;
  mode_t       mode_now, mode_planned;
  logic        last_dir;
  logic [5:0]  hi, lo;
  logic [4:0]  rider_count;
  logic [5:0]  waiter_count;
  logic [31:0] time_count, cost_count, wait_sum;
  logic [15:0] boarded_count;
  logic        arrival, start_hit, ok;
  logic [5:0]  idx, k;
  logic [4:0]  j;
  logic [15:0] req_id;
  logic [5:0]  req_start, req_dest;

  rider_t  r_rd, r_j;
  waiter_t w_rd;
  logic    idx_lt_r, idx_lt_w, j_lt_r, w_up, board_ok, add_bad;
  logic [5:0] floor_moved;

  assign r_rd     = rider_tab[idx[3:0]];
  assign r_j      = rider_tab[j[3:0]];
  assign w_rd     = waiter_tab[idx[4:0]];
  assign idx_lt_r = idx < {1'b0, rider_count};
  assign idx_lt_w = idx < waiter_count;
  assign j_lt_r   = j < rider_count;
  assign w_up     = w_rd.dest > w_rd.start;
  assign board_ok = (w_rd.start == floor_now) &&
                    ((w_up == last_dir) || (hi == floor_now) || (lo == floor_now));
  assign add_bad  = (waiter_count >= 6'(WAIT_CAP)) || (start_floor == 6'd0) ||
                    (start_floor > 6'(FLOORS)) || (dest_floor == 6'd0) ||
                    (dest_floor > 6'(FLOORS));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    floor_moved = floor_now;
    if (mode_planned == M_UP && floor_now < 6'(FLOORS)) begin
      floor_moved = floor_now + 6'd1;
    end else if (mode_planned == M_DOWN && floor_now > 6'd1) begin
      floor_moved = floor_now - 6'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!action) begin
            state_next = S_MOVE;
          end else if (add_bad) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_ADD_SCAN;
          end
        end
      end
      S_ADD_SCAN: begin
        if (!idx_lt_w || w_rd.id == req_id) begin
          state_next = S_FINISH;
        end
      end
      S_MOVE: state_next = S_SCAN_R;
      S_SCAN_R: begin
        if (!idx_lt_r) begin
          state_next = S_SCAN_W;
        end
      end
      S_SCAN_W: begin
        if (!idx_lt_w) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (arrival) begin
          state_next = (mode_now == M_OPEN) ? S_ALIGHT : S_FINISH;
        end else if (start_hit) begin
          state_next = (mode_now == M_OPEN) ? S_BOARD : S_FINISH;
        end else begin
          state_next = S_AGE;
        end
      end
      S_ALIGHT: begin
        if (!idx_lt_r) begin
          state_next = S_FINISH;
        end
      end
      S_BOARD: begin
        if (!idx_lt_w) begin
          state_next = S_FINISH;
        end else if (board_ok && rider_count < 5'(RIDE_CAP)) begin
          state_next = S_BOARD_DUP;
        end
      end
      S_BOARD_DUP: begin
        if (!j_lt_r || r_j.id == w_rd.id) begin
          state_next = S_BOARD;
        end
      end
      S_AGE: begin
        if (!idx_lt_w) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_now     <= 6'd1;
      mode_now      <= M_HOLD;
      mode_planned  <= M_HOLD;
      last_dir      <= 1'b1;
      hi            <= 6'd1;
      lo            <= 6'd1;
      rider_count   <= '0;
      waiter_count  <= '0;
      time_count    <= '0;
      cost_count    <= '0;
      wait_sum      <= '0;
      boarded_count <= '0;
      out_valid     <= 1'b0;
      arrival       <= 1'b0;
      start_hit     <= 1'b0;
      ok            <= 1'b0;
      idx           <= '0;
      k             <= '0;
      j             <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          idx       <= '0;
          req_id    <= passenger_id;
          req_start <= start_floor;
          req_dest  <= dest_floor;
          ok        <= 1'b0;
        end
        S_ADD_SCAN: begin
          if (idx_lt_w) begin
            idx <= idx + 6'd1;
          end else begin
            waiter_tab[waiter_count[4:0]] <= '{id: req_id, start: req_start,
                                              dest: req_dest, wait_cnt: 16'd0};
            waiter_count <= waiter_count + 6'd1;
            ok           <= 1'b1;
          end
        end
        S_MOVE: begin
          case (mode_planned)
            M_UP, M_DOWN: begin
              if (floor_moved != floor_now) begin
                last_dir   <= (mode_planned == M_UP);
                time_count <= sat_add32(time_count, 32'd1);
                cost_count <= sat_add32(cost_count, 32'(MOVE_COST));
              end
            end
            M_OPEN: time_count <= sat_add32(time_count, 32'd1);
            M_CLOSE: begin
              time_count <= sat_add32(time_count, 32'd1);
              cost_count <= sat_add32(cost_count, 32'(CLOSE_COST));
            end
            default: ;
          endcase
          floor_now <= floor_moved;
          mode_now  <= mode_planned;
          hi        <= floor_moved;
          lo        <= floor_moved;
          arrival   <= 1'b0;
          start_hit <= 1'b0;
          ok        <= 1'b1;
          idx       <= '0;
        end
        S_SCAN_R: begin
          if (idx_lt_r) begin
            if (r_rd.dest > hi) hi <= r_rd.dest;
            if (r_rd.dest < lo) lo <= r_rd.dest;
            if (r_rd.dest == floor_now) arrival <= 1'b1;
            idx <= idx + 6'd1;
          end else begin
            idx <= '0;
          end
        end
        S_SCAN_W: begin
          if (idx_lt_w) begin
            if (w_rd.start > hi) hi <= w_rd.start;
            if (w_rd.start < lo) lo <= w_rd.start;
            if (w_rd.start == floor_now && w_up == last_dir) start_hit <= 1'b1;
            idx <= idx + 6'd1;
          end
        end
        S_DECIDE: begin
          idx <= '0;
          k   <= '0;
          if (arrival) begin
            case (mode_now)
              M_OPEN, M_HOLD, M_CLOSE: mode_planned <= M_OPEN;
              default: mode_planned <= M_HOLD;
            endcase
          end else if (start_hit) begin
            case (mode_now)
              M_UP, M_DOWN: mode_planned <= M_HOLD;
              default: mode_planned <= M_OPEN;
            endcase
          end else begin
            case (mode_now)
              M_UP: mode_planned <= (hi > floor_now) ? M_UP :
                                    (lo < floor_now) ? M_DOWN : M_HOLD;
              M_DOWN: mode_planned <= (lo < floor_now) ? M_DOWN :
                                      (hi > floor_now) ? M_UP : M_HOLD;
              M_HOLD: begin
                if (last_dir) begin
                  mode_planned <= (hi > floor_now) ? M_UP :
                                  (lo < floor_now) ? M_DOWN : M_STOP;
                end else begin
                  mode_planned <= (lo < floor_now) ? M_DOWN :
                                  (hi > floor_now) ? M_UP : M_STOP;
                end
              end
              M_OPEN: mode_planned <= M_CLOSE;
              M_CLOSE: mode_planned <= M_HOLD;
              default: begin
                if (hi > floor_now) begin
                  mode_planned <= M_HOLD;
                  last_dir     <= 1'b1;
                end else if (lo < floor_now) begin
                  mode_planned <= M_DOWN;
                  last_dir     <= 1'b0;
                end else begin
                  mode_planned <= M_STOP;
                end
              end
            endcase
          end
        end
        S_ALIGHT: begin
          if (idx_lt_r) begin
            if (r_rd.dest != floor_now) begin
              rider_tab[k[3:0]] <= r_rd;
              k <= k + 6'd1;
            end
            idx <= idx + 6'd1;
          end else begin
            rider_count <= k[4:0];
          end
        end
        S_BOARD: begin
          j <= '0;
          if (idx_lt_w) begin
            if (!(board_ok && rider_count < 5'(RIDE_CAP))) begin
              waiter_tab[k[4:0]] <= w_rd;
              k   <= k + 6'd1;
              idx <= idx + 6'd1;
            end
          end else begin
            waiter_count <= k;
          end
        end
        S_BOARD_DUP: begin
          if (j_lt_r && r_j.id == w_rd.id) begin
            waiter_tab[k[4:0]] <= w_rd;
            k   <= k + 6'd1;
            idx <= idx + 6'd1;
          end else if (j_lt_r) begin
            j <= j + 5'd1;
          end else begin
            rider_tab[rider_count[3:0]] <= '{id: w_rd.id, dest: w_rd.dest};
            rider_count   <= rider_count + 5'd1;
            boarded_count <= sat_inc16(boarded_count);
            wait_sum      <= sat_add32(wait_sum, {16'd0, w_rd.wait_cnt});
            if (w_rd.dest > hi) hi <= w_rd.dest;
            if (w_rd.dest < lo) lo <= w_rd.dest;
            idx <= idx + 6'd1;
          end
        end
        S_AGE: begin
          if (idx_lt_w) begin
            waiter_tab[idx[4:0]].wait_cnt <= sat_inc16(w_rd.wait_cnt);
            idx <= idx + 6'd1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            accepted      <= ok;
            car_floor     <= floor_now;
            car_mode      <= mode_now;
            riders        <= rider_count;
            waiters       <= waiter_count;
            elapsed_steps <= time_count;
            energy_cost   <= cost_count;
            boarded_total <= boarded_count;
            wait_total    <= wait_sum;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
